FILE: rtl/pdisp_pkg.sv
// Shared types and constants for the periodic task dispatcher.
package pdisp_pkg;

    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    localparam int OP_W    = 2;
    localparam int PRIO_W  = 16;
    localparam int TIME_W  = 32;
    localparam int NAME_W  = 8;
    localparam int STAT_W  = 3;
    localparam int ID_W    = 4;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 8;

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_CREATED     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_CREATE_FAIL = 3'd1;
    localparam logic [STAT_W-1:0] STAT_STARTED     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DUE         = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NONE        = 3'd4;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [PRIO_W-1:0]    prio_t;
    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [MAX_TASKS-1:0] mask_t;

endpackage

FILE: rtl/periodic_task_dispatcher.sv
// Periodic task dispatcher: task table, due check and priority-ordered dispatch.
//
// channel  direction  tdata (low bit up)                                tuser        tlast
// s_axis   in         priority_req[15:0] period_ms[47:16]              op[1:0]      -
//                     name_length[55:48] now_ms[87:56]
// m_axis   out        task_id[3:0], zero fill to 8 bits                 status[2:0]  last
//
// Create and start: result held in pend registers, then output in the emit step.
// Tick: a due check over every slot; then, per due task, a select pass over every
// slot and an emit step; with no task due, a single emit step follows the check.
// One shared 32-bit subtract/compare unit visits one slot a cycle.
// Input is taken only while idle; a held result stalls the emit step.
// Reset clears slot use flags and run stamps at once; no clearing pass.
module periodic_task_dispatcher
    import pdisp_pkg::*;
#(
    parameter int MAX_NAME = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // priority_req, period_ms, name_length, now_ms
    input  logic [OP_W-1:0]      s_axis_tuser,   // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // task_id
    output logic [STAT_W-1:0]    m_axis_tuser,   // status
    output logic                 m_axis_tlast
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_SELECT = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]        state_reg, state_next;
    idx_t              idx_reg, idx_next;
    mask_t             due_reg, due_next;
    logic              best_valid_reg, best_valid_next;
    prio_t             best_prio_reg, best_prio_next;
    idx_t              best_idx_reg, best_idx_next;
    time_t             now_reg, now_next;
    logic [STAT_W-1:0] pend_status_reg, pend_status_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic              pend_last_reg, pend_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic              out_last_reg, out_last_next;
    mask_t             slot_used_reg, slot_used_next;

    prio_t             prio_reg [MAX_TASKS];
    time_t             period_reg [MAX_TASKS];
    time_t             last_run_reg [MAX_TASKS];

    logic [OP_W-1:0]   in_op;
    prio_t             in_prio;
    time_t             in_period;
    logic [NAME_W-1:0] in_name_len;
    time_t             in_now;
    logic              accept;

    logic              free_found;
    idx_t              free_idx;
    logic              create_we;
    logic              start_we;
    logic              stamp_we;

    time_t             cmp_a, cmp_b;
    logic              cmp_lt;
    logic              check_due;
    logic              cand_better;
    logic              last_idx;
    idx_t              sel_idx;
    mask_t             due_set;
    mask_t             due_left;
    logic              out_free;

    assign in_op       = s_axis_tuser;
    assign in_prio     = s_axis_tdata[15:0];
    assign in_period   = s_axis_tdata[47:16];
    assign in_name_len = s_axis_tdata[55:48];
    assign in_now      = s_axis_tdata[87:56];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_id_reg);
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (!slot_used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // shared unit: elapsed-vs-period during check, priority-vs-best during select
    always_comb
    begin
        if (state_reg == ST_CHECK)
        begin
            cmp_a = now_reg - last_run_reg[idx_reg];
            cmp_b = period_reg[idx_reg];
        end
        else
        begin
            cmp_a = TIME_W'(prio_reg[idx_reg]);
            cmp_b = TIME_W'(best_prio_reg);
        end
    end

    assign cmp_lt      = (cmp_a < cmp_b);
    assign check_due   = slot_used_reg[idx_reg] && !cmp_lt;
    assign cand_better = due_reg[idx_reg] && (!best_valid_reg || cmp_lt);
    assign last_idx    = (idx_reg == IDX_W'(MAX_TASKS - 1));
    assign sel_idx     = cand_better ? idx_reg : best_idx_reg;
    assign due_set     = due_reg | (mask_t'(check_due) << idx_reg);
    assign due_left    = due_reg & ~(mask_t'(1) << sel_idx);
    assign out_free    = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        due_next         = due_reg;
        best_valid_next  = best_valid_reg;
        best_prio_next   = best_prio_reg;
        best_idx_next    = best_idx_reg;
        now_next         = now_reg;
        pend_status_next = pend_status_reg;
        pend_id_next     = pend_id_reg;
        pend_last_next   = pend_last_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_last_next    = out_last_reg;
        slot_used_next   = slot_used_reg;
        create_we        = 1'b0;
        start_we         = 1'b0;
        stamp_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_last_next = 1'b1;
                    pend_id_next   = '0;
                    case (in_op)
                        OP_CREATE:
                        begin
                            state_next = ST_EMIT;
                            if ((in_name_len > NAME_W'(MAX_NAME)) || !free_found)
                            begin
                                pend_status_next = STAT_CREATE_FAIL;
                            end
                            else
                            begin
                                create_we                = 1'b1;
                                slot_used_next[free_idx] = 1'b1;
                                pend_status_next         = STAT_CREATED;
                                pend_id_next             = ID_W'(free_idx) + ID_W'(1);
                            end
                        end
                        OP_START:
                        begin
                            start_we         = 1'b1;
                            pend_status_next = STAT_STARTED;
                            state_next       = ST_EMIT;
                        end
                        OP_TICK:
                        begin
                            now_next   = in_now;
                            idx_next   = '0;
                            due_next   = '0;
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                due_next = due_set;
                if (last_idx)
                begin
                    idx_next = '0;
                    if (due_set == '0)
                    begin
                        pend_status_next = STAT_NONE;
                        pend_id_next     = '0;
                        pend_last_next   = 1'b1;
                        state_next       = ST_EMIT;
                    end
                    else
                    begin
                        best_valid_next = 1'b0;
                        state_next      = ST_SELECT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SELECT:
            begin
                if (cand_better)
                begin
                    best_valid_next = 1'b1;
                    best_prio_next  = prio_reg[idx_reg];
                    best_idx_next   = idx_reg;
                end
                if (last_idx)
                begin
                    best_idx_next    = sel_idx;
                    pend_status_next = STAT_DUE;
                    pend_id_next     = ID_W'(sel_idx) + ID_W'(1);
                    pend_last_next   = (due_left == '0);
                    idx_next         = '0;
                    state_next       = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_id_next     = pend_id_reg;
                    out_last_next   = pend_last_reg;
                    if (pend_status_reg == STAT_DUE)
                    begin
                        stamp_we               = 1'b1;
                        due_next[best_idx_reg] = 1'b0;
                    end
                    if (pend_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next        = '0;
                        best_valid_next = 1'b0;
                        state_next      = ST_SELECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            due_reg        <= '0;
            best_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_used_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            due_reg        <= due_next;
            best_valid_reg <= best_valid_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
            slot_used_reg  <= slot_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_prio_reg   <= best_prio_next;
        best_idx_reg    <= best_idx_next;
        now_reg         <= now_next;
        pend_status_reg <= pend_status_next;
        pend_id_reg     <= pend_id_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_last_reg    <= out_last_next;
        if (create_we)
        begin
            prio_reg[free_idx]   <= in_prio;
            period_reg[free_idx] <= in_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                last_run_reg[i] <= '0;
            end
        end
        else if (start_we)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                last_run_reg[i] <= in_now;
            end
        end
        else if (stamp_we)
        begin
            last_run_reg[best_idx_reg] <= now_reg;
        end
    end

endmodule

FILE: tb/periodic_task_dispatcher_chk.sv
// Checker for the periodic task dispatcher: predicts dispatch results and compares them.
`timescale 1ns / 100ps

module periodic_task_dispatcher_chk
    import pdisp_pkg::*;
#(
    parameter int MAX_NAME = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [OP_W-1:0]      s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic [STAT_W-1:0]    m_axis_tuser,
    input  logic                 m_axis_tlast,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [M_TDATA_W-1:0] id;
        logic                 last;
    } dispatch_t;

    dispatch_t dispatch_q[$];
    dispatch_t want;

    logic  slot_busy  [MAX_TASKS];
    prio_t slot_prio  [MAX_TASKS];
    time_t slot_period[MAX_TASKS];
    time_t slot_stamp [MAX_TASKS];

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic push_result(input logic [STAT_W-1:0] status, input int id, input logic last);
        dispatch_t r;
        r.status = status;
        r.id     = M_TDATA_W'(id);
        r.last   = last;
        dispatch_q.push_back(r);
    endtask

    task automatic predict_dispatch(input logic [OP_W-1:0] op, input prio_t prio,
                                    input time_t period, input logic [NAME_W-1:0] name_len,
                                    input time_t now);
        mask_t due;
        int    best;
        int    free_slot;
        due       = '0;
        free_slot = -1;
        case (op)
            OP_CREATE:
            begin
                if (int'(name_len) > MAX_NAME)
                begin
                    push_result(STAT_CREATE_FAIL, 0, 1'b1);
                end
                else
                begin
                    for (int i = MAX_TASKS - 1; i >= 0; i--)
                        if (!slot_busy[i])
                            free_slot = i;
                    if (free_slot < 0)
                    begin
                        push_result(STAT_CREATE_FAIL, 0, 1'b1);
                    end
                    else
                    begin
                        slot_busy[free_slot]   = 1'b1;
                        slot_prio[free_slot]   = prio;
                        slot_period[free_slot] = period;
                        push_result(STAT_CREATED, free_slot + 1, 1'b1);
                    end
                end
            end
            OP_START:
            begin
                for (int i = 0; i < MAX_TASKS; i++)
                    slot_stamp[i] = now;
                push_result(STAT_STARTED, 0, 1'b1);
            end
            OP_TICK:
            begin
                for (int i = 0; i < MAX_TASKS; i++)
                    due[i] = slot_busy[i] && (time_t'(now - slot_stamp[i]) >= slot_period[i]);
                if (due == '0)
                    push_result(STAT_NONE, 0, 1'b1);
                // lowest priority value first, lower slot wins a tie
                while (due != '0)
                begin
                    best = -1;
                    for (int i = 0; i < MAX_TASKS; i++)
                        if (due[i] && (best < 0 || slot_prio[i] < slot_prio[best]))
                            best = i;
                    due[best]        = 1'b0;
                    slot_stamp[best] = now;
                    push_result(STAT_DUE, best + 1, due == '0);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                slot_busy[i]   = 1'b0;
                slot_prio[i]   = '0;
                slot_period[i] = '0;
                slot_stamp[i]  = '0;
            end
            dispatch_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_dispatch(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16],
                                 s_axis_tdata[55:48], s_axis_tdata[87:56]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (dispatch_q.size() == 0)
                begin
                    report($sformatf("unexpected result status %0d id %0d last %0b",
                                     m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end
                else
                begin
                    want = dispatch_q.pop_front();
                    if (m_axis_tuser !== want.status)
                        report($sformatf("status expected %0d got %0d",
                                         want.status, m_axis_tuser));
                    if (m_axis_tdata !== want.id)
                        report($sformatf("task_id expected %0d got %0d",
                                         want.id, m_axis_tdata));
                    if (m_axis_tlast !== want.last)
                        report($sformatf("last expected %0b got %0b",
                                         want.last, m_axis_tlast));
                end
            end
            pending <= dispatch_q.size();
        end
    end

endmodule

FILE: tb/periodic_task_dispatcher_tb.sv
// Top-level testbench for the periodic task dispatcher: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module periodic_task_dispatcher_tb;
    import pdisp_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int NAME_LIMIT   = 16;
    localparam int RANDOM_ITEMS = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [OP_W-1:0]      s_axis_tuser  = '0;
    logic                 m_axis_tready = 1'b0;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;

    int   fail_count;
    int   pending;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    periodic_task_dispatcher #(.MAX_NAME(NAME_LIMIT)) dut (.*);

    periodic_task_dispatcher_chk #(.MAX_NAME(NAME_LIMIT)) chk (.*);

    // receiver: random backpressure, one long hold-off, a stretch with none
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= rx_steady || ($urandom_range(0, 99) >= 37);
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_txn(input logic [OP_W-1:0] op, input prio_t prio, input time_t period,
                            input logic [NAME_W-1:0] name_len, input time_t now);
        while (!tx_steady && $urandom_range(0, 99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, name_len, period, prio};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
    endtask

    initial
    begin
        time_t clk_ms;
        int    n;
        int    pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: tick reports nothing due
        send_txn(OP_TICK, prio_t'($urandom), $urandom, NAME_W'($urandom), '0);
        // name too long while slots are free
        send_txn(OP_CREATE, prio_t'($urandom), $urandom, 8'(NAME_LIMIT + 1), $urandom);
        send_txn(OP_CREATE, prio_t'($urandom), $urandom, 8'hFF, $urandom);
        // extremes of priority, period and name length
        send_txn(OP_CREATE, 16'hFFFF, '0, 8'(NAME_LIMIT), $urandom);
        send_txn(OP_CREATE, 16'h0000, 32'hFFFF_FFFF, 8'h00, $urandom);
        // fill the table, small priorities for ties
        repeat (MAX_TASKS - 2)
            send_txn(OP_CREATE, prio_t'($urandom_range(0, 7)), time_t'($urandom_range(10, 400)),
                     8'($urandom_range(0, NAME_LIMIT)), $urandom);
        // table full
        send_txn(OP_CREATE, prio_t'($urandom), $urandom, 8'h00, $urandom);
        send_txn(OP_IGNORED, prio_t'($urandom), $urandom, NAME_W'($urandom), $urandom);
        // max elapsed time: every task due, in priority order
        send_txn(OP_START, prio_t'($urandom), $urandom, NAME_W'($urandom), '0);
        send_txn(OP_TICK, prio_t'($urandom), $urandom, NAME_W'($urandom), 32'hFFFF_FFFF);
        send_txn(OP_TICK, prio_t'($urandom), $urandom, NAME_W'($urandom), 32'hFFFF_FFFF);
        // elapsed time across the wrap
        send_txn(OP_START, prio_t'($urandom), $urandom, NAME_W'($urandom), 32'hFFFF_FF00);
        send_txn(OP_TICK, prio_t'($urandom), $urandom, NAME_W'($urandom), 32'h0000_0010);
        send_txn(OP_TICK, prio_t'($urandom), $urandom, NAME_W'($urandom), 32'h0000_0011);

        clk_ms = 32'hFFFF_F000;
        send_txn(OP_START, prio_t'($urandom), $urandom, NAME_W'($urandom), clk_ms);

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (n == 30)
                hold_req <= 1'b1;
            if (n == 60)
                drain_results();
            tx_steady <= (n >= 70 && n < 100);
            rx_steady <= (n >= 70 && n < 100);
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                if (pick < 4)
                    clk_ms = $urandom;
                else
                    clk_ms = clk_ms + time_t'($urandom_range(0, 150));
                send_txn(OP_TICK, prio_t'($urandom), $urandom, NAME_W'($urandom), clk_ms);
                n++;
            end
            else if (pick < 85)
            begin
                send_txn(OP_START, prio_t'($urandom), $urandom, NAME_W'($urandom), clk_ms);
                n++;
            end
            else if (pick < 95)
            begin
                send_txn(OP_CREATE, prio_t'($urandom), $urandom, NAME_W'($urandom), $urandom);
                n++;
            end
            else
            begin
                send_txn(OP_IGNORED, prio_t'($urandom), $urandom, NAME_W'($urandom), $urandom);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/pdisp_pkg.sv
rtl/periodic_task_dispatcher.sv
tb/periodic_task_dispatcher_chk.sv
tb/periodic_task_dispatcher_tb.sv
